// ----- rtl/lcg_pkg.sv -----
// ----------------------------------------------------------------------------
// lcg_pkg
// Shared types and constants of the linear congruential generator.
// ----------------------------------------------------------------------------
package lcg_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned PROD_W     = 2 * VALUE_W;
  localparam int unsigned CNT_W      = $clog2(PROD_W);
  localparam int unsigned CFG_ADDR_W = 2;

  localparam logic [VALUE_W-1:0] MODULUS_RST    = VALUE_W'(9);
  localparam logic [VALUE_W-1:0] MULTIPLIER_RST = VALUE_W'(4);
  localparam logic [VALUE_W-1:0] INCREMENT_RST  = VALUE_W'(1);
  localparam logic [VALUE_W-1:0] SEED_RST       = '0;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MODULUS    = 2'd0,
    REG_MULTIPLIER = 2'd1,
    REG_INCREMENT  = 2'd2,
    REG_SEED       = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [VALUE_W-1:0] modulus;
    logic [VALUE_W-1:0] multiplier;
    logic [VALUE_W-1:0] increment;
    logic [VALUE_W-1:0] seed;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [VALUE_W-1:0] modulus;
  } mod_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] remainder;
  } mod_rsp_t;

endpackage

// ----- rtl/lcg_in_if.sv -----
// ----------------------------------------------------------------------------
// lcg_in_if
// Tick channel: one word carries the restart flag.
// ----------------------------------------------------------------------------
interface lcg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// ----- rtl/lcg_out_if.sv -----
// ----------------------------------------------------------------------------
// lcg_out_if
// Result channel: one word carries the sequence value.
// ----------------------------------------------------------------------------
interface lcg_out_if;
  logic                        valid;
  logic                        ready;
  logic [lcg_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ----- rtl/lcg_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lcg_cfg_regs
// Configuration register file: modulus, multiplier, increment and seed.
// ----------------------------------------------------------------------------
module lcg_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lcg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lcg_pkg::CFG_W-1:0]      cfg_wdata,
  output lcg_pkg::cfg_t                  cfg
);

  lcg_pkg::cfg_t               cfg_r;
  logic [lcg_pkg::VALUE_W-1:0] wval;

  assign wval = cfg_wdata[lcg_pkg::VALUE_W-1:0];
  assign cfg  = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.modulus    <= lcg_pkg::MODULUS_RST;
      cfg_r.multiplier <= lcg_pkg::MULTIPLIER_RST;
      cfg_r.increment  <= lcg_pkg::INCREMENT_RST;
      cfg_r.seed       <= lcg_pkg::SEED_RST;
    end else if (cfg_we) begin
      unique case (lcg_pkg::cfg_reg_t'(cfg_addr))
        lcg_pkg::REG_MODULUS:    cfg_r.modulus    <= wval;
        lcg_pkg::REG_MULTIPLIER: cfg_r.multiplier <= wval;
        lcg_pkg::REG_INCREMENT:  cfg_r.increment  <= wval;
        lcg_pkg::REG_SEED:       cfg_r.seed       <= wval;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/lcg_mod_unit.sv -----
// ----------------------------------------------------------------------------
// lcg_mod_unit
// Restoring remainder unit: reduces a double-width word by the modulus,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lcg_mod_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  lcg_pkg::mod_req_t   req,
  output lcg_pkg::mod_rsp_t   rsp
);

  logic                        busy_r;
  logic                        done_r;
  logic [lcg_pkg::CNT_W-1:0]   cnt_r;
  logic [lcg_pkg::PROD_W-1:0]  dividend_r;
  logic [lcg_pkg::VALUE_W-1:0] rem_r;
  logic [lcg_pkg::VALUE_W-1:0] rem_nxt;
  logic [lcg_pkg::VALUE_W:0]   trial;
  logic [lcg_pkg::VALUE_W:0]   divisor;

  assign trial   = {rem_r, dividend_r[lcg_pkg::PROD_W-1]};
  assign divisor = {1'b0, req.modulus};

  always_comb begin
    if (trial >= divisor) begin
      rem_nxt = lcg_pkg::VALUE_W'(trial - divisor);
    end else begin
      rem_nxt = trial[lcg_pkg::VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= lcg_pkg::CNT_W'(lcg_pkg::PROD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - lcg_pkg::CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dividend_r <= req.dividend;
      rem_r      <= '0;
    end else if (busy_r) begin
      dividend_r <= {dividend_r[lcg_pkg::PROD_W-2:0], 1'b0};
      rem_r      <= rem_nxt;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;

endmodule

// ----- rtl/lcg_seq.sv -----
// ----------------------------------------------------------------------------
// lcg_seq
// Step sequencer: multiplies, adds the increment, hands a nonzero-modulus
// sum to the remainder unit and holds the current value and output register.
// ----------------------------------------------------------------------------
module lcg_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lcg_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_restart,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lcg_pkg::VALUE_W-1:0] out_value,
  output lcg_pkg::mod_req_t           mod_req,
  input  lcg_pkg::mod_rsp_t           mod_rsp
);

  lcg_pkg::state_t             state_r;
  lcg_pkg::state_t             state_nxt;
  logic [lcg_pkg::VALUE_W-1:0] cur_r;
  logic [lcg_pkg::PROD_W-1:0]  prod_r;
  logic [lcg_pkg::PROD_W-1:0]  sum;
  logic                        out_valid_r;
  logic [lcg_pkg::VALUE_W-1:0] out_value_r;
  logic                        accept;
  logic                        mod_zero;
  logic                        out_free;
  logic                        load_out;
  logic                        div_start;

  assign accept   = in_valid && in_ready;
  assign mod_zero = (cfg.modulus == '0);
  assign out_free = !out_valid_r || out_ready;
  assign sum      = prod_r + lcg_pkg::PROD_W'(cfg.increment);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lcg_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = in_restart ? lcg_pkg::S_OUT : lcg_pkg::S_MUL;
        end
      end
      lcg_pkg::S_MUL: state_nxt = lcg_pkg::S_ADD;
      lcg_pkg::S_ADD: state_nxt = mod_zero ? lcg_pkg::S_OUT : lcg_pkg::S_DIV;
      lcg_pkg::S_DIV: begin
        if (mod_rsp.done) begin
          state_nxt = lcg_pkg::S_OUT;
        end
      end
      lcg_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = lcg_pkg::S_IDLE;
        end
      end
      default: state_nxt = lcg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == lcg_pkg::S_IDLE);
    div_start = (state_r == lcg_pkg::S_ADD) && !mod_zero;
    load_out  = (state_r == lcg_pkg::S_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcg_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      cur_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept && in_restart) begin
        cur_r <= cfg.seed;
      end else if ((state_r == lcg_pkg::S_ADD) && mod_zero) begin
        cur_r <= sum[lcg_pkg::VALUE_W-1:0];
      end else if ((state_r == lcg_pkg::S_DIV) && mod_rsp.done) begin
        cur_r <= mod_rsp.remainder;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == lcg_pkg::S_MUL) begin
      prod_r <= lcg_pkg::PROD_W'(cfg.multiplier) * lcg_pkg::PROD_W'(cur_r);
    end
    if (load_out) begin
      out_value_r <= cur_r;
    end
  end

  always_comb begin
    mod_req.start    = div_start;
    mod_req.dividend = sum;
    mod_req.modulus  = cfg.modulus;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule

// ----- rtl/linear_congruential_generator.sv -----
// ----------------------------------------------------------------------------
// linear_congruential_generator
// Mixed linear congruential generator, value = (a * value + c) mod m.
//
// Usage: the modulus, multiplier, increment and seed are written through the
// cfg_ port (index 0 to 3) while the block is idle. Each word on the in_if
// channel is one tick: with restart set the seed is loaded and returned,
// otherwise the sequence advances one step and the new value is returned
// as one word on the out_if channel. A zero modulus wraps at 2^32.
// Steps: a restart word loads the seed into the current value, which then goes
// to the output register. An advance passes the multiply, the add, the
// restoring remainder unit that reduces the exact 64-bit sum one bit per cycle,
// the taking of the remainder and the load of the output register. A zero
// modulus skips the remainder unit. Only one word is in work at a time: the
// input is ready again in the cycle after the output register is loaded.
// Reset: the registers return to modulus 9, multiplier 4, increment 1 and
// seed 0, and the current value is cleared to 0.
// Stall: a finished word waits in the output register; the sequencer holds
// its result until the register is free and takes no new tick meanwhile.
// ----------------------------------------------------------------------------
module linear_congruential_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  lcg_in_if.sink                         in_if,
  lcg_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [lcg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lcg_pkg::CFG_W-1:0]      cfg_wdata
);

  lcg_pkg::cfg_t     cfg;
  lcg_pkg::mod_req_t mod_req;
  lcg_pkg::mod_rsp_t mod_rsp;

  lcg_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lcg_mod_unit u_mod_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  lcg_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_restart (in_if.restart),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_value  (out_if.value),
    .mod_req    (mod_req),
    .mod_rsp    (mod_rsp)
  );

endmodule

// ----- tb/linear_congruential_generator_tb.sv -----
// ----------------------------------------------------------------------------
// linear_congruential_generator_tb
// Self-checking bench for the linear congruential generator. A queue of ticks
// feeds a clocked driver, and a clocked monitor checks every returned word
// against values worked out at full width when each tick is accepted. A
// directed set covers the corner cases: ticks before any restart, a seed not
// below the modulus, oversized factors, a zero modulus and the 32-bit
// extremes. The last directed set holds the output off long enough to back the
// block up, and random phases then vary the registers and the flow control.
// ----------------------------------------------------------------------------
module linear_congruential_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned TAIL_CYCLES   = 100;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_PHASES = 24;
  localparam int unsigned PHASE_TICKS   = 30;
  localparam int unsigned RESTART_PCT   = 8;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  lcg_pkg::cfg_reg_t         cfg_addr;
  logic [lcg_pkg::CFG_W-1:0] cfg_wdata;

  lcg_in_if  in_ch ();
  lcg_out_if out_ch ();

  logic [lcg_pkg::VALUE_W-1:0] gen_modulus;
  logic [lcg_pkg::VALUE_W-1:0] gen_multiplier;
  logic [lcg_pkg::VALUE_W-1:0] gen_increment;
  logic [lcg_pkg::VALUE_W-1:0] gen_seed;
  logic [lcg_pkg::VALUE_W-1:0] gen_value;
  logic [lcg_pkg::VALUE_W-1:0] value_q[$];
  logic [lcg_pkg::VALUE_W-1:0] want_value;
  logic                        tick_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  logic        hold_go = 1'b0;
  logic        hold_out;

  linear_congruential_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void step_sequence(input logic restart);
    logic [lcg_pkg::PROD_W-1:0] full;
    if (restart) begin
      gen_value = gen_seed;
    end else begin
      full = lcg_pkg::PROD_W'(gen_multiplier) * lcg_pkg::PROD_W'(gen_value)
             + lcg_pkg::PROD_W'(gen_increment);
      if (gen_modulus == '0) begin
        gen_value = full[lcg_pkg::VALUE_W-1:0];
      end else begin
        gen_value = lcg_pkg::VALUE_W'(full % lcg_pkg::PROD_W'(gen_modulus));
      end
    end
    value_q.push_back(gen_value);
  endfunction

  function automatic logic [lcg_pkg::CFG_W-1:0] pick_word();
    case ($urandom_range(4))
      0: return '0;
      1: return lcg_pkg::CFG_W'($urandom_range(16));
      2: return '1;
      3: return lcg_pkg::CFG_W'(1) << $urandom_range(lcg_pkg::CFG_W - 1);
      default: return lcg_pkg::CFG_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [lcg_pkg::VALUE_W-1:0] want,
                                 input logic [lcg_pkg::VALUE_W-1:0] got);
    $display("[%0t] %s: expected %08h, got %08h", $realtime, what, want, got);
    err_cnt++;
  endtask

  task automatic write_reg(input lcg_pkg::cfg_reg_t idx,
                           input logic [lcg_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    case (idx)
      lcg_pkg::REG_MODULUS:    gen_modulus    = data[lcg_pkg::VALUE_W-1:0];
      lcg_pkg::REG_MULTIPLIER: gen_multiplier = data[lcg_pkg::VALUE_W-1:0];
      lcg_pkg::REG_INCREMENT:  gen_increment  = data[lcg_pkg::VALUE_W-1:0];
      lcg_pkg::REG_SEED:       gen_seed       = data[lcg_pkg::VALUE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [lcg_pkg::CFG_W-1:0] m,
                              input logic [lcg_pkg::CFG_W-1:0] a,
                              input logic [lcg_pkg::CFG_W-1:0] c,
                              input logic [lcg_pkg::CFG_W-1:0] s);
    write_reg(lcg_pkg::REG_MODULUS, m);
    write_reg(lcg_pkg::REG_MULTIPLIER, a);
    write_reg(lcg_pkg::REG_INCREMENT, c);
    write_reg(lcg_pkg::REG_SEED, s);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_ch.valid || value_q.size() != 0);
  endtask

  task automatic queue_ticks(input int unsigned n, input int unsigned restart_pct);
    repeat (n) tick_q.push_back($urandom_range(99) < restart_pct);
  endtask

  // Tick driver: a word is offered only when the previous one has gone.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        step_sequence(in_ch.restart);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid   <= 1'b1;
          in_ch.restart <= tick_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (value_q.size() == 0) begin
        report_mismatch("unexpected word", '0, out_ch.value);
      end else begin
        want_value = value_q.pop_front();
        if (out_ch.value !== want_value) begin
          report_mismatch("value", want_value, out_ch.value);
        end
      end
    end
    out_ch.ready <= rst_n && !hold_out && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long hold-off on the output side, timed here while the driver keeps going.
  initial begin
    hold_out = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = lcg_pkg::REG_MODULUS;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.restart  = 1'b0;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    err_cnt        = 0;
    cycle_cnt      = 0;
    gen_modulus    = lcg_pkg::MODULUS_RST;
    gen_multiplier = lcg_pkg::MULTIPLIER_RST;
    gen_increment  = lcg_pkg::INCREMENT_RST;
    gen_seed       = lcg_pkg::SEED_RST;
    gen_value      = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Ticks before any restart advance from zero under the reset settings.
    queue_ticks(3, 0);
    queue_ticks(1, 100);
    queue_ticks(2, 0);

    wait_idle();
    program_regs(32'd1000, 32'd7, 32'd13, 32'hFFFF_FFFF);
    queue_ticks(1, 100);
    queue_ticks(2, 0);

    wait_idle();
    program_regs(32'd97, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'd5);
    queue_ticks(1, 100);
    queue_ticks(2, 0);

    wait_idle();
    program_regs('0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_ticks(1, 100);
    queue_ticks(3, 0);

    wait_idle();
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    queue_ticks(1, 100);
    queue_ticks(2, 0);

    wait_idle();
    program_regs(32'd1, '0, '0, 32'h8000_0000);
    queue_ticks(1, 100);
    queue_ticks(1, 0);

    wait_idle();
    program_regs(32'd65521, 32'd75, 32'd74, 32'd1);
    hold_go = 1'b1;
    queue_ticks(12, 25);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      program_regs(pick_word(), pick_word(), pick_word(), pick_word());
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 83;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 83;
        end
        default: begin
          send_idle_pct  = 33;
          recv_stall_pct = 33;
        end
      endcase
      queue_ticks(PHASE_TICKS, RESTART_PCT);
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
